### src/assert_macros.svh
// Concurrent assertion helpers; compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### src/mnbm_pkg.sv
`timescale 1ns / 1ps
package mnbm_pkg;

	localparam int MAX_ROWS = 1024;
	localparam int MAX_COLS = 1024;
	localparam int MAX_DIM  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;

	localparam int IDX_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DIM_W      = 11;
	localparam int ELEM_W     = 32;
	localparam int THR_W      = 31;
	localparam int SUM_W      = 48;
	localparam int BAND_W     = 10;
	localparam int BAND_MAX   = (1 << BAND_W) - 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 120;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_COUNT = 2'd0,
		REG_COL_COUNT = 2'd1,
		REG_ZERO_THR  = 2'd2
	} cfg_reg_t;

	// element with its position, handed from the counters to the datapath
	typedef struct packed {
		logic signed [ELEM_W-1:0] value;
		logic [IDX_W-1:0]         row;
		logic [IDX_W-1:0]         col;
		logic                     first_row;
		logic                     last_col;
		logic                     last_row;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0] row_idx;
		logic [IDX_W-1:0] col_idx;
		logic [IDX_W:0]   rows;
		logic [IDX_W:0]   cols;
		logic [THR_W-1:0] threshold;
		logic             rearm;
	} ctrl_status_t;

	typedef struct packed {
		logic [BAND_W-1:0] upper_bandwidth;
		logic [BAND_W-1:0] lower_bandwidth;
		logic [SUM_W-1:0]  col_norm_max;
		logic [SUM_W-1:0]  row_norm_max;
	} result_t;

	// zero acts as one, anything above the maximum acts as the maximum
	function automatic logic [IDX_W:0] clamp_dim(input logic [DIM_W-1:0] v, input int top);
		logic [IDX_W:0] r;
		if (v == '0) begin
			r = (IDX_W + 1)'(1);
		end else if (32'(v) > top) begin
			r = (IDX_W + 1)'(top);
		end else begin
			r = (IDX_W + 1)'(v);
		end
		return r;
	endfunction

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
			input logic [ELEM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {{(SUM_W + 1 - ELEM_W){1'b0}}, b};
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

endpackage

### src/mnbm_ctrl.sv
`timescale 1ns / 1ps
module mnbm_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [mnbm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mnbm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                accept,
	input  logic signed [mnbm_pkg::ELEM_W-1:0]  element_value,
	output mnbm_pkg::item_t                     item,
	output mnbm_pkg::ctrl_status_t              status
);
	import mnbm_pkg::*;

	logic [DIM_W-1:0] row_count_q;
	logic [DIM_W-1:0] col_count_q;
	logic [THR_W-1:0] thr_q;
	logic [IDX_W-1:0] row_idx_q;
	logic [IDX_W-1:0] col_idx_q;
	logic             rearm;
	logic [IDX_W:0]   rows;
	logic [IDX_W:0]   cols;
	logic             last_col;
	logic             last_row;

	assign rows = clamp_dim(row_count_q, MAX_ROWS);
	assign cols = clamp_dim(col_count_q, MAX_COLS);

	assign last_col = ({1'b0, col_idx_q} + (IDX_W + 1)'(1)) >= cols;
	assign last_row = ({1'b0, row_idx_q} + (IDX_W + 1)'(1)) >= rows;

	always_comb begin
		rearm = 1'b0;
		if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ROW_COUNT: rearm = 1'b1;
				REG_COL_COUNT: rearm = 1'b1;
				REG_ZERO_THR:  rearm = 1'b0;
				default:       rearm = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= DIM_W'(1);
			col_count_q <= DIM_W'(1);
			thr_q       <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ROW_COUNT: row_count_q <= cfg_data[DIM_W-1:0];
				REG_COL_COUNT: col_count_q <= cfg_data[DIM_W-1:0];
				REG_ZERO_THR:  thr_q       <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_idx_q <= '0;
			col_idx_q <= '0;
		end else if (rearm) begin
			row_idx_q <= '0;
			col_idx_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_idx_q <= '0;
				row_idx_q <= last_row ? '0 : row_idx_q + IDX_W'(1);
			end else begin
				col_idx_q <= col_idx_q + IDX_W'(1);
			end
		end
	end

	assign item.value     = element_value;
	assign item.row       = row_idx_q;
	assign item.col       = col_idx_q;
	assign item.first_row = (row_idx_q == '0);
	assign item.last_col  = last_col;
	assign item.last_row  = last_row;

	assign status.row_idx   = row_idx_q;
	assign status.col_idx   = col_idx_q;
	assign status.rows      = rows;
	assign status.cols      = cols;
	assign status.threshold = thr_q;
	assign status.rearm     = rearm;

endmodule

### src/mnbm_colmem.sv
`timescale 1ns / 1ps
module mnbm_colmem (
	input  logic                          clk,
	input  logic                          rd_en,
	input  logic [mnbm_pkg::IDX_W-1:0]    rd_addr,
	output logic [mnbm_pkg::SUM_W-1:0]    rd_data,
	input  logic                          wr_en,
	input  logic [mnbm_pkg::IDX_W-1:0]    wr_addr,
	input  logic [mnbm_pkg::SUM_W-1:0]    wr_data
);
	import mnbm_pkg::*;

	logic [SUM_W-1:0] mem [MAX_COLS];
	logic [SUM_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// write-first: a read of the entry being written returns the new sum
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_q <= wr_data;
			end else begin
				rd_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_q;

endmodule

### src/mnbm_accum.sv
`timescale 1ns / 1ps
module mnbm_accum (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  mnbm_pkg::item_t         item,
	input  mnbm_pkg::ctrl_status_t  status,
	output logic                    stall,
	output logic                    out_valid,
	input  logic                    out_ready,
	output mnbm_pkg::result_t       result
);
	import mnbm_pkg::*;

	logic             valid_s1;
	item_t            item_s1;
	logic [SUM_W-1:0] col_rd;

	logic [SUM_W-1:0]  row_sum_q;
	logic [SUM_W-1:0]  row_max_q;
	logic [SUM_W-1:0]  col_max_q;
	logic [BAND_W-1:0] lower_q;
	logic [BAND_W-1:0] upper_q;
	logic              out_valid_q;
	result_t           out_res_q;

	logic              advance;
	logic              final_s1;
	logic [ELEM_W-1:0] mag;
	logic [SUM_W-1:0]  row_sum_nx;
	logic [SUM_W-1:0]  col_sum_nx;
	logic [SUM_W-1:0]  row_max_nx;
	logic [SUM_W-1:0]  col_max_nx;
	logic [BAND_W-1:0] lower_nx;
	logic [BAND_W-1:0] upper_nx;
	logic [IDX_W-1:0]  diff;
	logic [BAND_W-1:0] band;
	logic              above;

	assign final_s1 = item_s1.last_row && item_s1.last_col;
	assign stall    = valid_s1 && final_s1 && out_valid_q && !out_ready;
	assign advance  = valid_s1 && !stall;

	mnbm_colmem u_colmem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (status.col_idx),
		.rd_data (col_rd),
		.wr_en   (advance),
		.wr_addr (item_s1.col),
		.wr_data (col_sum_nx)
	);

	always_comb begin
		mag = item_s1.value[ELEM_W-1] ? ELEM_W'(-item_s1.value) : ELEM_W'(item_s1.value);
		row_sum_nx = sat_add(row_sum_q, mag);
		// first row seeds the column sum, the stale entry is never used
		col_sum_nx = item_s1.first_row ? SUM_W'(mag) : sat_add(col_rd, mag);

		above = mag > {1'b0, status.threshold};
		diff  = (item_s1.row > item_s1.col) ? item_s1.row - item_s1.col
			: item_s1.col - item_s1.row;
		band  = (32'(diff) > BAND_MAX) ? BAND_W'(BAND_MAX) : BAND_W'(diff);

		lower_nx = lower_q;
		upper_nx = upper_q;
		if (above && (item_s1.row > item_s1.col) && (band > lower_q)) begin
			lower_nx = band;
		end
		if (above && (item_s1.col > item_s1.row) && (band > upper_q)) begin
			upper_nx = band;
		end

		col_max_nx = col_max_q;
		if (item_s1.last_row && (col_sum_nx > col_max_q)) begin
			col_max_nx = col_sum_nx;
		end

		row_max_nx = row_max_q;
		if (item_s1.last_col && (row_sum_nx > row_max_q)) begin
			row_max_nx = row_sum_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (status.rearm) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_sum_q <= '0;
			row_max_q <= '0;
			col_max_q <= '0;
			lower_q   <= '0;
			upper_q   <= '0;
		end else if (status.rearm) begin
			row_sum_q <= '0;
			row_max_q <= '0;
			col_max_q <= '0;
			lower_q   <= '0;
			upper_q   <= '0;
		end else if (advance) begin
			if (final_s1) begin
				row_sum_q <= '0;
				row_max_q <= '0;
				col_max_q <= '0;
				lower_q   <= '0;
				upper_q   <= '0;
			end else begin
				row_sum_q <= item_s1.last_col ? '0 : row_sum_nx;
				row_max_q <= row_max_nx;
				col_max_q <= col_max_nx;
				lower_q   <= lower_nx;
				upper_q   <= upper_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && final_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && final_s1) begin
			out_res_q.row_norm_max    <= row_max_nx;
			out_res_q.col_norm_max    <= col_max_nx;
			out_res_q.lower_bandwidth <= lower_nx;
			out_res_q.upper_bandwidth <= upper_nx;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = out_res_q;

endmodule

### src/matrix_norm_bandwidth_monitor.sv
`timescale 1ns / 1ps
// Channel   | Direction | Beat contents
// s_axis    | in        | one matrix element, row-major order
// m_axis    | out       | norms and bandwidths, one beat per matrix
// cfg       | in        | register write: index and data
//
// One element per cycle unless stalled; the result beat is registered: the last
// element passes the input register, then the result register.
// The column sums live in a 1024-entry RAM, read as the element is taken and
// written as it leaves the input stage, write-first bypass for back-to-back hits.
// Reset needs no clearing pass: row 0 seeds every column sum. The input stalls
// only when a result is due while the previous beat waits on m_axis_tready.
module matrix_norm_bandwidth_monitor (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// [31:0] element_value
	input  logic [mnbm_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// [47:0] row_norm_max, [95:48] col_norm_max, [105:96] lower_bandwidth,
	// [115:106] upper_bandwidth, [119:116] zero
	output logic [mnbm_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [mnbm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mnbm_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import mnbm_pkg::*;
	`include "assert_macros.svh"

	logic         accept;
	logic         stall;
	item_t        item;
	ctrl_status_t status;
	result_t      result;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !stall;
	assign accept        = s_axis_tvalid && s_axis_tready;

	mnbm_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.accept        (accept),
		.element_value (s_axis_tdata[ELEM_W-1:0]),
		.item          (item),
		.status        (status)
	);

	mnbm_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.status    (status),
		.stall     (stall),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.result    (result)
	);

	assign m_axis_tdata = {{(OUT_TDATA_W - 2 * SUM_W - 2 * BAND_W){1'b0}},
		result.upper_bandwidth, result.lower_bandwidth,
		result.col_norm_max, result.row_norm_max};

	`ASSERT_HOLDS(a_stall_only_on_full_out, clk, arst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
	`ASSERT_HOLDS(a_col_in_range, clk, arst_n, 1'b1, ({1'b0, status.col_idx} < status.cols))
	`ASSERT_HOLDS(a_row_in_range, clk, arst_n, 1'b1, ({1'b0, status.row_idx} < status.rows))
	`ASSERT_NEXT(a_dim_write_rearms, clk, arst_n, cfg_valid && (cfg_index == REG_ROW_COUNT || cfg_index == REG_COL_COUNT), status.row_idx == '0 && status.col_idx == '0)

endmodule
